// File: rtl/tpr_pkg.sv
// Shared types, constants and the frame checksum for the telemetry poll responder.
package tpr_pkg;

    localparam int unsigned TABLE_DEPTH = 32;
    localparam int unsigned IDX_W       = $clog2(TABLE_DEPTH);
    localparam int unsigned FRAME_LEN   = 8;
    localparam int unsigned CNT_W       = $clog2(FRAME_LEN);
    localparam int unsigned ADDR_W      = 5;

    localparam logic [7:0]  START_BYTE   = 8'h7E;
    localparam logic [7:0]  FRAME_HEADER = 8'h10;
    localparam logic [15:0] EMPTY_ID     = 16'hFFFF;

    localparam logic [0:0] ACT_RX_BYTE = 1'b0;
    localparam logic [0:0] ACT_LOAD    = 1'b1;

    localparam logic [2:0] REG_ID_A    = 3'd0;
    localparam logic [2:0] REG_ID_B    = 3'd1;
    localparam logic [2:0] REG_ID_C    = 3'd2;
    localparam logic [2:0] REG_ID_D    = 3'd3;
    localparam logic [2:0] REG_ENTRIES = 3'd4;

    localparam logic [7:0] RST_ID_A    = 8'h1B;
    localparam logic [7:0] RST_ID_B    = 8'h0D;
    localparam logic [7:0] RST_ID_C    = 8'h34;
    localparam logic [7:0] RST_ID_D    = 8'h67;
    localparam logic [5:0] RST_ENTRIES = 6'd22;

    typedef struct packed {
        logic [0:0]  action;
        logic [7:0]  rx_byte;
        logic [4:0]  entry_index;
        logic [15:0] entry_id;
        logic [31:0] entry_value;
    } t_in_item;

    typedef struct packed {
        logic [7:0] tx_byte;
        logic       frame_end;
    } t_out_item;

    typedef struct packed {
        logic [7:0] sensor_id_a;
        logic [7:0] sensor_id_b;
        logic [7:0] sensor_id_c;
        logic [7:0] sensor_id_d;
        logic [5:0] entries_in_use;
    } t_cfg;

    typedef struct packed {
        logic [15:0] id;
        logic [31:0] value;
    } t_slot;

    localparam int unsigned SLOT_W = $bits(t_slot);

    // Byte sum of the seven frame bytes with end-around carry, taken from 0xFF.
    // Add all bytes at once, then fold the carries back in twice.
    function automatic logic [7:0] frame_checksum(input logic [55:0] body);
        logic [10:0] total;
        logic [8:0]  fold;
        total = 11'd0;
        for (int k = 0; k < 7; k++) begin
            total = total + {3'd0, body[k*8 +: 8]};
        end
        fold = {1'b0, total[7:0]} + {6'd0, total[10:8]};
        fold = {1'b0, fold[7:0]} + {8'd0, fold[8]};
        return 8'hFF - fold[7:0];
    endfunction

endpackage

// File: rtl/tpr_ram.sv
// Generic single-write, single-read RAM with registered read data.
module tpr_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// File: rtl/tpr_cfg.sv
// APB register bank: polled sensor IDs and rotation length.
module tpr_cfg (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [tpr_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0]                pwdata,
    output logic [31:0]                prdata,
    output tpr_pkg::t_cfg              o_cfg
);
    import tpr_pkg::*;

    t_cfg       r_cfg;
    logic       w_wr;
    logic [2:0] w_reg;

    assign w_wr  = psel && penable && pwrite;
    assign w_reg = paddr[4:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.sensor_id_a    <= RST_ID_A;
            r_cfg.sensor_id_b    <= RST_ID_B;
            r_cfg.sensor_id_c    <= RST_ID_C;
            r_cfg.sensor_id_d    <= RST_ID_D;
            r_cfg.entries_in_use <= RST_ENTRIES;
        end else if (w_wr) begin
            unique case (w_reg)
                REG_ID_A:    r_cfg.sensor_id_a    <= pwdata[7:0];
                REG_ID_B:    r_cfg.sensor_id_b    <= pwdata[7:0];
                REG_ID_C:    r_cfg.sensor_id_c    <= pwdata[7:0];
                REG_ID_D:    r_cfg.sensor_id_d    <= pwdata[7:0];
                REG_ENTRIES: r_cfg.entries_in_use <= pwdata[5:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (w_reg)
            REG_ID_A:    prdata = {24'd0, r_cfg.sensor_id_a};
            REG_ID_B:    prdata = {24'd0, r_cfg.sensor_id_b};
            REG_ID_C:    prdata = {24'd0, r_cfg.sensor_id_c};
            REG_ID_D:    prdata = {24'd0, r_cfg.sensor_id_d};
            REG_ENTRIES: prdata = {26'd0, r_cfg.entries_in_use};
            default:     prdata = 32'd0;
        endcase
    end

    assign o_cfg = r_cfg;

endmodule

// File: rtl/tpr_poll.sv
// Poll detector: previous byte, sensor ID match, rotation index and table access.
module tpr_poll (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  tpr_pkg::t_cfg             i_cfg,
    input  logic                      i_accept,
    input  tpr_pkg::t_in_item         i_item,
    output logic                      o_wr_en,
    output logic [tpr_pkg::IDX_W-1:0] o_wr_addr,
    output tpr_pkg::t_slot            o_wr_data,
    output logic                      o_rd_en,
    output logic [tpr_pkg::IDX_W-1:0] o_rd_addr
);
    import tpr_pkg::*;

    logic [7:0]       r_prev;
    logic [IDX_W-1:0] r_rot;
    logic [IDX_W:0]   w_inc;
    logic             w_sat;
    logic             w_wrap;
    logic [IDX_W-1:0] n_rot;
    logic             w_rx;
    logic             w_match;
    logic             w_poll;

    assign w_rx    = i_accept && (i_item.action == ACT_RX_BYTE);
    assign w_match = (i_item.rx_byte == i_cfg.sensor_id_a) ||
                     (i_item.rx_byte == i_cfg.sensor_id_b) ||
                     (i_item.rx_byte == i_cfg.sensor_id_c) ||
                     (i_item.rx_byte == i_cfg.sensor_id_d);
    assign w_poll  = w_rx && (r_prev == START_BYTE) && w_match;

    // Advance first, wrap at the (saturated) rotation length.
    assign w_inc  = {1'b0, r_rot} + {{IDX_W{1'b0}}, 1'b1};
    assign w_sat  = 32'(i_cfg.entries_in_use) > TABLE_DEPTH;
    assign w_wrap = w_sat ? (32'(w_inc) >= TABLE_DEPTH)
                          : (32'(w_inc) >= 32'(i_cfg.entries_in_use));
    assign n_rot  = w_wrap ? '0 : w_inc[IDX_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev <= 8'd0;
            r_rot  <= '0;
        end else begin
            if (w_rx) begin
                r_prev <= i_item.rx_byte;
            end
            if (w_poll) begin
                r_rot <= n_rot;
            end
        end
    end

    assign o_wr_en         = i_accept && (i_item.action == ACT_LOAD) &&
                             (32'(i_item.entry_index) < TABLE_DEPTH);
    assign o_wr_addr       = IDX_W'(i_item.entry_index);
    assign o_wr_data.id    = i_item.entry_id;
    assign o_wr_data.value = i_item.entry_value;
    assign o_rd_en         = w_poll;
    assign o_rd_addr       = n_rot;

endmodule

// File: rtl/tpr_frame.sv
// Reply framer: frames each non-empty slot read back and shifts it out.
module tpr_frame (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_rd_issue,
    input  tpr_pkg::t_slot     i_rd_data,
    output logic               o_stall,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output tpr_pkg::t_out_item o_out_data
);
    import tpr_pkg::*;

    logic                   r_rd_vld;
    logic                   r_busy;
    logic [CNT_W-1:0]       r_cnt;
    logic [FRAME_LEN*8-1:0] r_frame;
    logic [55:0]            w_body;
    logic                   w_empty;
    logic                   w_load;
    logic                   w_drop;
    logic                   w_xfer;
    logic                   w_last;

    assign w_body  = {i_rd_data.value, i_rd_data.id, FRAME_HEADER};
    assign w_empty = (i_rd_data.id == EMPTY_ID);
    // Load when idle, or as the checksum byte of the current frame leaves.
    assign w_load  = r_rd_vld && !w_empty && (!r_busy || (w_xfer && w_last));
    assign w_drop  = r_rd_vld && w_empty;
    assign w_xfer  = r_busy && i_out_ready;
    assign w_last  = (r_cnt == CNT_W'(FRAME_LEN - 1));
    assign o_stall = r_rd_vld && !w_load && !w_drop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_vld <= 1'b0;
            r_busy   <= 1'b0;
            r_cnt    <= '0;
        end else begin
            if (i_rd_issue) begin
                r_rd_vld <= 1'b1;
            end else if (w_load || w_drop) begin
                r_rd_vld <= 1'b0;
            end
            if (w_load) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (w_xfer) begin
                // Drop busy after the checksum byte; the count advances on every transfer.
                if (w_last) begin
                    r_busy <= 1'b0;
                end
                r_cnt <= r_cnt + CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_frame <= {frame_checksum(w_body), w_body};
        end else if (w_xfer) begin
            r_frame <= {8'd0, r_frame[FRAME_LEN*8-1:8]};
        end
    end

    assign o_out_valid          = r_busy;
    assign o_out_data.tx_byte   = r_frame[7:0];
    assign o_out_data.frame_end = w_last;

    a_load_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_load |-> (!r_busy || (w_xfer && w_last)))
        else $error("frame loaded over a frame in flight");

    a_pending_kept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rd_vld && !w_load && !w_drop |=> r_rd_vld)
        else $error("pending slot read lost");

    a_issue_gated: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rd_issue |-> (!r_rd_vld || w_load || w_drop))
        else $error("slot read issued over an unresolved read");

    a_end_frees: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_xfer && w_last && !w_load |=> !r_busy)
        else $error("framer still busy after checksum byte");

endmodule

// File: rtl/telemetry_poll_responder.sv
// Top level of the telemetry poll responder: register bank, poll logic, slot RAM, framer.
//
//  channel  | handshake                 | payload
//  ---------+---------------------------+-----------------------------------
//  input    | i_in_valid / o_in_ready   | i_in_data  (t_in_item)
//  output   | o_out_valid / i_out_ready | o_out_data (t_out_item)
//  config   | psel, penable, pwrite     | paddr, pwdata, prdata, pready
//
// Link bytes and table loads transfer one per cycle while o_in_ready is high. A poll
// reads the slot RAM at its transfer; the read data is registered in the RAM, then
// loaded into the frame register, and the reply takes eight output transfers (none
// for an empty slot). A second poll may follow at once; its slot read waits in the RAM
// output register while the framer is busy, and input transfers stop only then. The next
// frame loads as the checksum byte leaves, so back-to-back replies follow without a gap.
// Synchronous reset restores control and config; frame and RAM data are not cleared.
module telemetry_poll_responder (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    output logic                       o_in_ready,
    input  tpr_pkg::t_in_item          i_in_data,
    output logic                       o_out_valid,
    input  logic                       i_out_ready,
    output tpr_pkg::t_out_item         o_out_data,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [tpr_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0]                pwdata,
    output logic [31:0]                prdata,
    output logic                       pready
);
    import tpr_pkg::*;

    t_cfg             w_cfg;
    logic             w_accept;
    logic             w_stall;
    logic             w_wr_en;
    logic [IDX_W-1:0] w_wr_addr;
    t_slot            w_wr_data;
    logic             w_rd_en;
    logic [IDX_W-1:0] w_rd_addr;
    logic [SLOT_W-1:0] w_rd_bits;

    assign pready     = 1'b1;
    assign o_in_ready = !w_stall;
    assign w_accept   = i_in_valid && o_in_ready;

    tpr_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .o_cfg   (w_cfg)
    );

    tpr_poll u_poll (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (w_cfg),
        .i_accept  (w_accept),
        .i_item    (i_in_data),
        .o_wr_en   (w_wr_en),
        .o_wr_addr (w_wr_addr),
        .o_wr_data (w_wr_data),
        .o_rd_en   (w_rd_en),
        .o_rd_addr (w_rd_addr)
    );

    tpr_ram #(
        .WIDTH (SLOT_W),
        .DEPTH (TABLE_DEPTH)
    ) u_slot_ram (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (w_wr_addr),
        .i_wr_data (w_wr_data),
        .i_rd_en   (w_rd_en),
        .i_rd_addr (w_rd_addr),
        .o_rd_data (w_rd_bits)
    );

    tpr_frame u_frame (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_rd_issue  (w_rd_en),
        .i_rd_data   (t_slot'(w_rd_bits)),
        .o_stall     (w_stall),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

endmodule
